FILE: design/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int FIELD_W          = 13;
    localparam int SIZE_W           = 13;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
    localparam logic [1:0] ST_ALLOC_FULL = 2'd1;
    localparam logic [1:0] ST_FREE_DONE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_WALK_RD,
        S_MERGE,
        S_MERGE_RD,
        S_EVAL,
        S_SPLIT,
        S_TAIL,
        S_FREE_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] granted_address;
        logic [1:0]         status;
        logic               grew_heap;
    } t_result;

endpackage

FILE: design/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a byte heap kept as an implicit list of headers.
// ----------------------------------------------------------------------------
// A request word enters on i_valid while o_stall is low: i_op selects an
// allocate or a free, with i_request_bytes or i_payload_address. Each word
// gives one result word on o_valid, held stable while i_stall is high.
// A free reads the header in front of the payload and marks it free; an
// address below the header size or with its header past the heap is ignored.
// An allocate walks the list from the start, reading each header; a free
// block first absorbs the free blocks that follow it. The first block large
// enough is taken, and split when the rest can hold a header; with no fit the
// block is appended at the break, or the heap is full.
// One word is in work at a time; the next is taken the cycle after the result
// has moved into the output register, so a stalled receiver holds off new
// words only after one finished result waits there.
// Reset sets the break to zero and empties the list; the header memory is not
// cleared, and the walk reads no entry at or beyond the break.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [ffha_pkg::FIELD_W-1:0] i_request_bytes,
    input  logic [ffha_pkg::FIELD_W-1:0] i_payload_address,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ffha_pkg::FIELD_W-1:0] o_granted_address,
    output logic [1:0]                   o_status,
    output logic                         o_grew_heap
);
    import ffha_pkg::*;

    logic    r_valid;
    t_result r_out;
    logic    res_valid, res_take;
    t_result res;

    ffha_seq #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_request_bytes  (i_request_bytes),
        .i_payload_address(i_payload_address),
        .o_res_valid      (res_valid),
        .i_res_take       (res_take),
        .o_res            (res)
    );

    assign res_take = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_take) begin
            r_valid <= res_valid;
        end
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_valid;
    assign o_granted_address = r_out.granted_address;
    assign o_status          = r_out.status;
    assign o_grew_heap       = r_out.grew_heap;
endmodule

FILE: design/ffha_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_mem
// Header store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/ffha_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_seq
// Sequencer that walks, merges, splits and extends the block list.
// ----------------------------------------------------------------------------
module ffha_seq #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [ffha_pkg::FIELD_W-1:0] i_request_bytes,
    input  logic [ffha_pkg::FIELD_W-1:0] i_payload_address,
    output logic                         o_res_valid,
    input  logic                         i_res_take,
    output ffha_pkg::t_result            o_res
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
    localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cur, n_cur;
    logic [CW-1:0]       r_pivot, n_pivot;
    logic [CW-1:0]       r_need, n_need;
    logic [CW-1:0]       r_brk, n_brk;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic                r_free, n_free;
    t_result             r_res, n_res;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [SIZE_W:0]     wdata, rdata;
    logic [CW-1:0]       hdr_addr, rd_size, rest;
    logic                rd_free;

    ffha_mem #(.DEPTH(HEAP_BYTES), .AW(AW), .DW(SIZE_W + 1)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rd_free  = rdata[SIZE_W];
    assign rd_size  = CW'(rdata[SIZE_W-1:0]);
    assign hdr_addr = CW'(i_payload_address) - HDR_C;
    assign rest     = r_cur + r_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_brk   <= '0;
        end else begin
            r_state <= n_state;
            r_brk   <= n_brk;
        end
        r_cur   <= n_cur;
        r_pivot <= n_pivot;
        r_need  <= n_need;
        r_size  <= n_size;
        r_free  <= n_free;
        r_res   <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_pivot = r_pivot;
        n_need  = r_need;
        n_brk   = r_brk;
        n_size  = r_size;
        n_free  = r_free;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = r_cur[AW-1:0];
        wdata   = {r_free, r_size};
        raddr   = r_cur[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                raddr = hdr_addr[AW-1:0];
                if (i_valid) begin
                    n_res = '{granted_address: '0, status: ST_FREE_DONE, grew_heap: 1'b0};
                    if (i_op == OP_FREE) begin
                        n_cur = hdr_addr;
                        if (CW'(i_payload_address) >= HDR_C && hdr_addr < HEAP_C) begin
                            n_state = S_FREE_WB;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_cur   = '0;
                        n_need  = CW'(i_request_bytes) + HDR_C;
                        n_state = S_WALK;
                    end
                end
            end
            S_FREE_WB: begin
                we      = 1'b1;
                wdata   = {1'b1, rdata[SIZE_W-1:0]};
                n_state = S_DONE;
            end
            S_WALK: begin
                if (r_cur < r_brk && r_cur < HEAP_C) begin
                    n_state = S_WALK_RD;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_WALK_RD: begin
                n_free  = rd_free;
                n_size  = rdata[SIZE_W-1:0];
                n_pivot = r_cur + rd_size;
                n_state = rd_free ? S_MERGE : S_EVAL;
            end
            S_MERGE: begin
                raddr = r_pivot[AW-1:0];
                if (r_pivot < r_brk && r_pivot < HEAP_C) begin
                    n_state = S_MERGE_RD;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_MERGE_RD: begin
                if (!rd_free || rd_size < HDR_C) begin
                    n_state = S_EVAL;
                end else begin
                    n_size  = r_size + rdata[SIZE_W-1:0];
                    n_pivot = r_pivot + rd_size;
                    n_state = S_MERGE;
                end
            end
            S_EVAL: begin
                we = r_free;
                if (r_free && CW'(r_size) >= HDR_C && CW'(r_size) >= r_need) begin
                    wdata = {1'b0, r_size};
                    if (CW'(r_size) >= r_need + HDR_C && rest < HEAP_C) begin
                        wdata   = {1'b0, r_need[SIZE_W-1:0]};
                        n_state = S_SPLIT;
                    end else begin
                        n_state = S_DONE;
                    end
                    n_res = '{granted_address: FIELD_W'(r_cur + HDR_C),
                              status: ST_ALLOC_OK, grew_heap: 1'b0};
                end else if (CW'(r_size) < HDR_C) begin
                    n_state = S_TAIL;
                end else begin
                    n_cur   = r_cur + CW'(r_size);
                    n_state = S_WALK;
                end
            end
            S_SPLIT: begin
                we      = 1'b1;
                waddr   = rest[AW-1:0];
                wdata   = {1'b1, SIZE_W'(CW'(r_size) - r_need)};
                n_state = S_DONE;
            end
            S_TAIL: begin
                waddr = r_brk[AW-1:0];
                wdata = {1'b0, r_need[SIZE_W-1:0]};
                if (r_brk < HEAP_C && r_need <= HEAP_C - r_brk) begin
                    we    = 1'b1;
                    n_brk = r_brk + r_need;
                    n_res = '{granted_address: FIELD_W'(r_brk + HDR_C),
                              status: ST_ALLOC_OK, grew_heap: 1'b1};
                end else begin
                    n_res = '{granted_address: '0, status: ST_ALLOC_FULL, grew_heap: 1'b0};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
endmodule
